FILE: rtl/core/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

   // Vertices per triangle, and orientation tests of one kind per triangle pair.
   localparam int TRI_VERTS  = 3;
   localparam int EDGE_TESTS = TRI_VERTS * TRI_VERTS;

   // Payload of one result item.
   typedef struct packed {
      logic edges_cross;
      logic first_holds_second;
   } tpr_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/tpr_if.sv
`default_nettype none

// Request channel: two triangles as twelve signed coordinates.
interface tpr_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_ax;
   logic signed [COORD_BITS-1:0] first_ay;
   logic signed [COORD_BITS-1:0] first_bx;
   logic signed [COORD_BITS-1:0] first_by;
   logic signed [COORD_BITS-1:0] first_cx;
   logic signed [COORD_BITS-1:0] first_cy;
   logic signed [COORD_BITS-1:0] second_ax;
   logic signed [COORD_BITS-1:0] second_ay;
   logic signed [COORD_BITS-1:0] second_bx;
   logic signed [COORD_BITS-1:0] second_by;
   logic signed [COORD_BITS-1:0] second_cx;
   logic signed [COORD_BITS-1:0] second_cy;

   modport source (
      output valid, first_ax, first_ay, first_bx, first_by, first_cx, first_cy,
             second_ax, second_ay, second_bx, second_by, second_cx, second_cy,
      input  ready
   );
   modport sink (
      input  valid, first_ax, first_ay, first_bx, first_by, first_cx, first_cy,
             second_ax, second_ay, second_bx, second_by, second_cx, second_cy,
      output ready
   );
endinterface

// Response channel: the two relation flags.
interface tpr_rsp_if;
   logic                valid;
   logic                ready;
   tpr_pkg::tpr_rsp_type payload;

   modport source (output valid, payload, input ready);
   modport sink (input valid, payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/triangle_pair_relation_unit.sv
// Throughput: one item per cycle; four register stages (differences, products,
// orientation compares, flag reduction) each hold one item, so a new item enters
// every cycle unless the response side stalls.
// Reset: synchronous, active high; clears all stage valid bits, payloads are not reset.
`default_nettype none

module triangle_pair_relation_unit #(
   parameter int COORD_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   tpr_req_if.sink     req_if,
   tpr_rsp_if.source   rsp_if
);

   // A coordinate difference needs one bit more than a coordinate, and a product
   // of two differences twice that.
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int VERTS     = tpr_pkg::TRI_VERTS;
   localparam int NTESTS    = tpr_pkg::EDGE_TESTS;
   // Tests 0..8 place a vertex of the first triangle against an edge of the
   // second; tests 9..17 place a vertex of the second against an edge of the first.
   localparam int ALL_TESTS = 2 * NTESTS;

   // Vertex coordinates, gathered so the test generators can index them.
   logic signed [COORD_BITS-1:0] t1x [VERTS];
   logic signed [COORD_BITS-1:0] t1y [VERTS];
   logic signed [COORD_BITS-1:0] t2x [VERTS];
   logic signed [COORD_BITS-1:0] t2y [VERTS];

   assign t1x[0] = req_if.first_ax;
   assign t1y[0] = req_if.first_ay;
   assign t1x[1] = req_if.first_bx;
   assign t1y[1] = req_if.first_by;
   assign t1x[2] = req_if.first_cx;
   assign t1y[2] = req_if.first_cy;
   assign t2x[0] = req_if.second_ax;
   assign t2y[0] = req_if.second_ay;
   assign t2x[1] = req_if.second_bx;
   assign t2y[1] = req_if.second_by;
   assign t2x[2] = req_if.second_cx;
   assign t2y[2] = req_if.second_cy;

   // Each orientation test ccw(P,Q,R) compares (Ry-Py)*(Qx-Px) against
   // (Qy-Py)*(Rx-Px). The points of every test are wired here.
   logic signed [COORD_BITS-1:0] px [ALL_TESTS];
   logic signed [COORD_BITS-1:0] py [ALL_TESTS];
   logic signed [COORD_BITS-1:0] qx [ALL_TESTS];
   logic signed [COORD_BITS-1:0] qy [ALL_TESTS];
   logic signed [COORD_BITS-1:0] rx [ALL_TESTS];
   logic signed [COORD_BITS-1:0] ry [ALL_TESTS];

   for (genvar i = 0; i < VERTS; i++) begin : g_pts_i
      for (genvar j = 0; j < VERTS; j++) begin : g_pts_j
         localparam int I1 = (i + 1) % VERTS;
         localparam int J1 = (j + 1) % VERTS;
         localparam int KA = VERTS * i + j;
         localparam int KB = NTESTS + VERTS * i + j;
         // Vertex i of the first triangle against edge j of the second.
         assign px[KA] = t1x[i];
         assign py[KA] = t1y[i];
         assign qx[KA] = t2x[j];
         assign qy[KA] = t2y[j];
         assign rx[KA] = t2x[J1];
         assign ry[KA] = t2y[J1];
         // Edge i of the first triangle against vertex j of the second.
         assign px[KB] = t1x[i];
         assign py[KB] = t1y[i];
         assign qx[KB] = t1x[I1];
         assign qy[KB] = t1y[I1];
         assign rx[KB] = t2x[j];
         assign ry[KB] = t2y[j];
      end
   end

   // Stage handshake. A stage loads when it is empty or its content moves on,
   // so the pipeline fills every slot and a stall holds every item in place.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;
   logic req_take;

   assign rdy4     = !v4_ff || rsp_if.ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign req_take = req_if.valid && rdy1;

   assign req_if.ready = rdy1;

   assign v1_in = rdy1 ? req_if.valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Stage 1 registers the four coordinate differences of each test, stage 2
   // the two products, stage 3 the strict comparison.
   logic signed [DIFF_BITS-1:0] dry_ff [ALL_TESTS];
   logic signed [DIFF_BITS-1:0] dqx_ff [ALL_TESTS];
   logic signed [DIFF_BITS-1:0] dqy_ff [ALL_TESTS];
   logic signed [DIFF_BITS-1:0] drx_ff [ALL_TESTS];
   logic signed [PROD_BITS-1:0] lhs_ff [ALL_TESTS];
   logic signed [PROD_BITS-1:0] rhs_ff [ALL_TESTS];
   logic [ALL_TESTS-1:0]        ccw_ff;

   for (genvar k = 0; k < ALL_TESTS; k++) begin : g_test
      logic signed [DIFF_BITS-1:0] dry_in, dqx_in, dqy_in, drx_in;
      logic signed [PROD_BITS-1:0] lhs_in, rhs_in;

      assign dry_in = $signed({ry[k][COORD_BITS-1], ry[k]})
                    - $signed({py[k][COORD_BITS-1], py[k]});
      assign dqx_in = $signed({qx[k][COORD_BITS-1], qx[k]})
                    - $signed({px[k][COORD_BITS-1], px[k]});
      assign dqy_in = $signed({qy[k][COORD_BITS-1], qy[k]})
                    - $signed({py[k][COORD_BITS-1], py[k]});
      assign drx_in = $signed({rx[k][COORD_BITS-1], rx[k]})
                    - $signed({px[k][COORD_BITS-1], px[k]});

      // Both operands are sign-extended to the product width, so the
      // products are exact.
      assign lhs_in = PROD_BITS'(dry_ff[k]) * PROD_BITS'(dqx_ff[k]);
      assign rhs_in = PROD_BITS'(dqy_ff[k]) * PROD_BITS'(drx_ff[k]);

      always_ff @(posedge clock) begin
         if (rdy1) begin
            dry_ff[k] <= dry_in;
            dqx_ff[k] <= dqx_in;
            dqy_ff[k] <= dqy_in;
            drx_ff[k] <= drx_in;
         end
         if (rdy2) begin
            lhs_ff[k] <= lhs_in;
            rhs_ff[k] <= rhs_in;
         end
         if (rdy3) begin
            ccw_ff[k] <= lhs_ff[k] > rhs_ff[k];
         end
      end
   end

   // Stage 4 reduces the eighteen orientation bits to the two flags. Edge pair
   // (i,j) crosses when the end points of edge i of the first triangle fall on
   // different sides of edge j of the other triangle, and the end points of
   // that edge j fall on different sides of edge i.
   logic [NTESTS-1:0]  pair_cross;
   logic [NTESTS-1:0]  side_bits;
   tpr_pkg::tpr_rsp_type rsp_in;
   tpr_pkg::tpr_rsp_type rsp_ff;

   for (genvar i = 0; i < VERTS; i++) begin : g_pair_i
      for (genvar j = 0; j < VERTS; j++) begin : g_pair_j
         localparam int I1 = (i + 1) % VERTS;
         localparam int J1 = (j + 1) % VERTS;
         assign pair_cross[VERTS*i+j] =
            (ccw_ff[VERTS*i+j] ^ ccw_ff[VERTS*I1+j])
            & (ccw_ff[NTESTS+VERTS*i+j] ^ ccw_ff[NTESTS+VERTS*i+J1]);
      end
   end

   assign side_bits = ccw_ff[ALL_TESTS-1:NTESTS];

   // The first triangle holds the second when nothing crosses and every vertex
   // of the second lies on the same side of every edge of the first, for
   // either winding of the first triangle.
   always_comb begin
      rsp_in.edges_cross        = |pair_cross;
      rsp_in.first_holds_second = !(|pair_cross) && ((&side_bits) || !(|side_bits));
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = v4_ff;
   assign rsp_if.payload = rsp_ff;

   // The two flags exclude each other by construction.
   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.payload.edges_cross && rsp_if.payload.first_holds_second))
      else $error("both relation flags set on one response item");

   // An accepted request item always occupies the first stage next cycle.
   a_take_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_take |=> v1_ff)
      else $error("accepted request item lost at the first stage");

   // Reset empties every stage.
   a_reset_empties : assert property (@(posedge clock)
      reset |=> !(v1_ff || v2_ff || v3_ff || v4_ff))
      else $error("pipeline stage valid after reset");

   // A stalled stage four keeps stage three from moving, so nothing is dropped.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rsp_if.ready && v3_ff) |=> (v3_ff && v4_ff))
      else $error("item dropped while the response side stalls");

endmodule

`default_nettype wire
